FILE: src/lavm_pkg.sv
// Shared constants and helper functions for the look-at view matrix block.
// No dependencies; compiled first.
package lavm_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_WORD_BITS = 32;
  localparam int FIELD_W       = 32;
  localparam int MAG_W         = 64;
  localparam int POS_W         = 7;
  // The largest nonzero block-scaled magnitude lands in [2^29, 2^30); the others are smaller
  localparam int SCALE_BITS    = 30;
  localparam int SCALE_TOP     = 29;
  localparam int ROOT_BITS     = 31;
  localparam int SUM_BITS      = 62;

  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_FWD   = 2'd2;
  localparam logic [1:0] ROW_CONST = 2'd3;

  function automatic logic [POS_W-1:0] msb_pos(input logic [MAG_W-1:0] m);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m[i]) begin
        p = POS_W'(i);
      end
    end
    return p;
  endfunction

  // Right shifts truncate, left shifts are exact
  function automatic logic [SCALE_BITS-1:0] scale_mag(input logic [MAG_W-1:0] mag,
                                                      input logic [POS_W-1:0] pos);
    logic [MAG_W-1:0] t;
    if (pos > POS_W'(SCALE_TOP)) begin
      t = mag >> (pos - POS_W'(SCALE_TOP));
    end else begin
      t = mag << (POS_W'(SCALE_TOP) - pos);
    end
    return t[SCALE_BITS-1:0];
  endfunction

endpackage

FILE: src/lavm_in_if.sv
// Input channel: eye, up hint and target, signed Q16.16 words.
// Depends on lavm_pkg.
interface lavm_in_if;
  import lavm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] eye_x;
  logic signed [FIELD_W-1:0] eye_y;
  logic signed [FIELD_W-1:0] eye_z;
  logic signed [FIELD_W-1:0] up_x;
  logic signed [FIELD_W-1:0] up_y;
  logic signed [FIELD_W-1:0] up_z;
  logic signed [FIELD_W-1:0] target_x;
  logic signed [FIELD_W-1:0] target_y;
  logic signed [FIELD_W-1:0] target_z;

  modport source (output valid, eye_x, eye_y, eye_z, up_x, up_y, up_z,
                  target_x, target_y, target_z, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, up_x, up_y, up_z,
                target_x, target_y, target_z, output ready);
endinterface

FILE: src/lavm_out_if.sv
// Output channel: one matrix row per beat.
// Depends on lavm_pkg.
interface lavm_out_if;
  import lavm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                row_index;
  logic signed [FIELD_W-1:0] elem0;
  logic signed [FIELD_W-1:0] elem1;
  logic signed [FIELD_W-1:0] elem2;
  logic signed [FIELD_W-1:0] elem3;
  logic                      degenerate;
  logic                      last_row;

  modport source (output valid, row_index, elem0, elem1, elem2, elem3, degenerate,
                  last_row, input ready);
  modport sink (input valid, row_index, elem0, elem1, elem2, elem3, degenerate,
                last_row, output ready);
endinterface

FILE: src/lavm_norm.sv
// Pipelined vector normaliser: block scale, sum of squares, bit-per-stage
// square root, bit-per-stage rounded division. Depends on lavm_pkg.
module lavm_norm #(
  parameter int IW        = 33,
  parameter int PW        = 8,
  parameter int FRAC_BITS = lavm_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [2:0][IW-1:0]             vin,
  input  logic [PW-1:0]                  in_pay,
  output logic                           out_valid,
  output logic [2:0][FRAC_BITS+1:0]      unit,
  output logic                           ok,
  output logic [PW-1:0]                  out_pay
);
  import lavm_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int UW   = F + 2;
  localparam int QW   = F + 1;
  localparam int DDW  = SCALE_BITS + F + 1;
  localparam int NSQ  = SUM_BITS / 2;
  localparam int RW   = ROOT_BITS;

  typedef struct packed {
    logic [PW-1:0]                    pay;
    logic [2:0]                       sgn;
    logic                             nz;
    logic [2:0][SCALE_BITS-1:0]       s;
  } nctx_t;

  // stage 1: magnitudes and maximum
  logic [2:0][IW-1:0] mag_c;
  logic [IW-1:0]      mx_c;
  always_comb begin
    mx_c = '0;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vin[i][IW-1] ? (~vin[i] + IW'(1)) : vin[i];
      if (mag_c[i] > mx_c) begin
        mx_c = mag_c[i];
      end
    end
  end

  logic               s1_v, s2_v, s3_v, s4_v;
  logic [2:0][IW-1:0] s1_mag, s2_mag;
  logic [2:0]         s1_sgn, s2_sgn;
  logic [IW-1:0]      s1_mx;
  logic [PW-1:0]      s1_pay, s2_pay;
  logic [POS_W-1:0]   s2_pos;
  logic               s2_nz;
  nctx_t              s3_ctx, s4_ctx;
  logic [2:0][2*SCALE_BITS-1:0] s4_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag <= mag_c;
      for (int i = 0; i < 3; i++) begin
        s1_sgn[i] <= vin[i][IW-1];
      end
      s1_mx  <= mx_c;
      s1_pay <= in_pay;

      s2_mag <= s1_mag;
      s2_sgn <= s1_sgn;
      s2_pos <= msb_pos(MAG_W'(s1_mx));
      s2_nz  <= |s1_mx;
      s2_pay <= s1_pay;

      for (int i = 0; i < 3; i++) begin
        s3_ctx.s[i] <= scale_mag(MAG_W'(s2_mag[i]), s2_pos);
      end
      s3_ctx.sgn <= s2_sgn;
      s3_ctx.nz  <= s2_nz;
      s3_ctx.pay <= s2_pay;

      s4_ctx <= s3_ctx;
      for (int i = 0; i < 3; i++) begin
        s4_sq[i] <= s3_ctx.s[i] * s3_ctx.s[i];
      end
    end
  end

  // square root, one result bit per stage
  logic              sq_v   [NSQ+1];
  nctx_t             sq_ctx [NSQ+1];
  logic [SUM_BITS-1:0] sq_x [NSQ+1];
  logic [RW:0]       sq_r   [NSQ+1];
  logic [RW-1:0]     sq_q   [NSQ+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_ctx[0] <= s4_ctx;
      sq_x[0]   <= SUM_BITS'(s4_sq[0]) + SUM_BITS'(s4_sq[1]) + SUM_BITS'(s4_sq[2]);
      sq_r[0]   <= '0;
      sq_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    logic [RW+2:0] r2;
    logic [RW+2:0] trial;
    logic          take;
    always_comb begin
      r2    = {1'b0, sq_r[k][RW-1:0], sq_x[k][SUM_BITS-1 -: 2]};
      trial = {1'b0, sq_q[k], 2'b01};
      take  = (r2 >= trial);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_ctx[k+1] <= sq_ctx[k];
        sq_x[k+1]   <= sq_x[k] << 2;
        sq_r[k+1]   <= take ? (RW+1)'(r2 - trial) : (RW+1)'(r2);
        sq_q[k+1]   <= {sq_q[k][RW-2:0], take};
      end
    end
  end

  // rounded division |s| * 2^F + n/2 by n, one quotient bit per stage
  logic               dv_v   [QW+1];
  nctx_t              dv_ctx [QW+1];
  logic [RW-1:0]      dv_n   [QW+1];
  logic [2:0][RW-1:0] dv_rem [QW+1];
  logic [2:0][QW-1:0] dv_low [QW+1];
  logic [2:0][QW-1:0] dv_q   [QW+1];

  logic [2:0][DDW-1:0] dd_c;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd_c[i] = {1'b0, sq_ctx[NSQ].s[i], {F{1'b0}}} + DDW'(sq_q[NSQ] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_ctx[0] <= sq_ctx[NSQ];
      dv_n[0]   <= sq_q[NSQ];
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= RW'(dd_c[i][DDW-1:QW]);
        dv_low[0][i] <= dd_c[i][QW-1:0];
        dv_q[0][i]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_dv
    logic [2:0][RW:0] r2;
    logic [2:0]       take;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i]   = {dv_rem[k][i], dv_low[k][i][QW-1]};
        take[i] = (r2[i] >= {1'b0, dv_n[k]});
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_ctx[k+1] <= dv_ctx[k];
        dv_n[k+1]   <= dv_n[k];
        for (int i = 0; i < 3; i++) begin
          dv_rem[k+1][i] <= take[i] ? RW'(r2[i] - {1'b0, dv_n[k]}) : RW'(r2[i]);
          dv_low[k+1][i] <= dv_low[k][i] << 1;
          dv_q[k+1][i]   <= {dv_q[k][i][QW-2:0], take[i]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        unit[i] <= dv_ctx[QW].sgn[i] ? (~{1'b0, dv_q[QW][i]} + UW'(1))
                                     : {1'b0, dv_q[QW][i]};
      end
      ok      <= dv_ctx[QW].nz;
      out_pay <= dv_ctx[QW].pay;
    end
  end

endmodule

FILE: src/look_at_view_matrix_top.sv
// Look-at view matrix generator: eye, up hint and target in, four matrix
// rows out (right, up, forward, constant). A point set is taken only while
// no matrix is held or as its last row goes out; the whole datapath is one
// stalling pipeline of about 3*FRAC_BITS + 128 register stages, dominated by
// the three normalisers (square root and division each resolve one bit per
// stage). Depends on lavm_pkg, lavm_in_if, lavm_out_if and lavm_norm.
module look_at_view_matrix_top #(
  parameter int FRAC_BITS = lavm_pkg::DEF_FRAC_BITS,
  parameter int WORD_BITS = lavm_pkg::DEF_WORD_BITS
) (
  input logic        clk,
  input logic        rst,
  lavm_in_if.sink    pts,
  lavm_out_if.source rows
);
  import lavm_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int UW  = F + 2;
  localparam int DW  = W + 1;
  localparam int USW = SCALE_BITS + 1;
  localparam int CW1 = UW + USW + 1;
  localparam int CW2 = 2 * UW + 1;
  localparam int SW  = ((W > 2 * F) ? W : 2 * F) + 8;
  localparam logic signed [SW-1:0] HI   = (SW'(1) << (W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] LO   = -HI - SW'(1);
  localparam logic signed [SW-1:0] HALF = SW'(1) << (F - 1);
  localparam logic signed [SW-1:0] ONE  = SW'(1) << F;

  typedef struct packed {
    logic [2:0][W-1:0]   eye;
    logic [2:0][USW-1:0] us;
    logic                unz;
  } p1_t;

  typedef struct packed {
    logic [2:0][W-1:0]  eye;
    logic [2:0][UW-1:0] f;
    logic               deg;
  } p2_t;

  typedef struct packed {
    logic [2:0][W-1:0]  eye;
    logic [2:0][UW-1:0] f;
    logic [2:0][UW-1:0] r;
    logic               deg;
  } p3_t;

  function automatic logic [W-1:0] ext_field(input logic [FIELD_W-1:0] v);
    logic [63:0] t;
    t = 64'(v) << (64 - W);
    return W'($signed(t) >>> (64 - W));
  endfunction

  function automatic logic [FIELD_W-1:0] fld(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] y;
    logic signed [63:0]   z;
    y = (x > HI) ? HI : ((x < LO) ? LO : x);
    z = 64'(y);
    return z[FIELD_W-1:0];
  endfunction

  logic en;
  logic acc_out;

  // front: difference, up hint block scale
  logic [FIELD_W-1:0] fin [9];
  assign fin[0] = pts.eye_x;
  assign fin[1] = pts.eye_y;
  assign fin[2] = pts.eye_z;
  assign fin[3] = pts.up_x;
  assign fin[4] = pts.up_y;
  assign fin[5] = pts.up_z;
  assign fin[6] = pts.target_x;
  assign fin[7] = pts.target_y;
  assign fin[8] = pts.target_z;

  logic [2:0][W-1:0] eye_c, up_c, tgt_c, umag_c;
  logic [W-1:0]      umx_c;
  always_comb begin
    umx_c = '0;
    for (int i = 0; i < 3; i++) begin
      eye_c[i]  = ext_field(fin[i]);
      up_c[i]   = ext_field(fin[3 + i]);
      tgt_c[i]  = ext_field(fin[6 + i]);
      umag_c[i] = up_c[i][W-1] ? (~up_c[i] + W'(1)) : up_c[i];
      if (umag_c[i] > umx_c) begin
        umx_c = umag_c[i];
      end
    end
  end

  logic                t1_v, t2_v, t3_v;
  logic [2:0][W-1:0]   t1_eye, t2_eye, t3_eye;
  logic [2:0][DW-1:0]  t1_d, t2_d, t3_d;
  logic [2:0][W-1:0]   t1_umag, t2_umag;
  logic [2:0]          t1_usgn, t2_usgn;
  logic [W-1:0]        t1_umx;
  logic [POS_W-1:0]    t2_upos;
  logic                t2_unz, t3_unz;
  logic [2:0][USW-1:0] t3_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
      t2_v <= 1'b0;
      t3_v <= 1'b0;
    end else if (en) begin
      t1_v <= pts.valid;
      t2_v <= t1_v;
      t3_v <= t2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_eye  <= eye_c;
      for (int i = 0; i < 3; i++) begin
        t1_d[i]    <= DW'($signed(tgt_c[i])) - DW'($signed(eye_c[i]));
        t1_usgn[i] <= up_c[i][W-1];
      end
      t1_umag <= umag_c;
      t1_umx  <= umx_c;

      t2_eye  <= t1_eye;
      t2_d    <= t1_d;
      t2_umag <= t1_umag;
      t2_usgn <= t1_usgn;
      t2_upos <= msb_pos(MAG_W'(t1_umx));
      t2_unz  <= |t1_umx;

      t3_eye <= t2_eye;
      t3_d   <= t2_d;
      t3_unz <= t2_unz;
      for (int i = 0; i < 3; i++) begin
        t3_us[i] <= t2_usgn[i] ? (~{1'b0, scale_mag(MAG_W'(t2_umag[i]), t2_upos)} + USW'(1))
                               : {1'b0, scale_mag(MAG_W'(t2_umag[i]), t2_upos)};
      end
    end
  end

  // forward axis
  p1_t                n1_in, n1_out;
  logic               n1_v, n1_ok;
  logic [2:0][UW-1:0] n1_f;
  assign n1_in = '{eye: t3_eye, us: t3_us, unz: t3_unz};

  lavm_norm #(.IW(DW), .PW($bits(p1_t)), .FRAC_BITS(F)) u_norm_f (
    .clk(clk), .rst(rst), .en(en), .in_valid(t3_v), .vin(t3_d), .in_pay(n1_in),
    .out_valid(n1_v), .unit(n1_f), .ok(n1_ok), .out_pay(n1_out)
  );

  // right = f x up
  logic                  c1_v, c2_v;
  logic signed [UW+USW-1:0] c1_p [6];
  p2_t                   c1_pay, c2_pay;
  logic [2:0][CW1-1:0]   c2_rc;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      c2_v <= 1'b0;
    end else if (en) begin
      c1_v <= n1_v;
      c2_v <= c1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_p[0] <= $signed(n1_f[1]) * $signed(n1_out.us[2]);
      c1_p[1] <= $signed(n1_f[2]) * $signed(n1_out.us[1]);
      c1_p[2] <= $signed(n1_f[2]) * $signed(n1_out.us[0]);
      c1_p[3] <= $signed(n1_f[0]) * $signed(n1_out.us[2]);
      c1_p[4] <= $signed(n1_f[0]) * $signed(n1_out.us[1]);
      c1_p[5] <= $signed(n1_f[1]) * $signed(n1_out.us[0]);
      c1_pay  <= '{eye: n1_out.eye, f: n1_f, deg: !n1_ok || !n1_out.unz};

      for (int i = 0; i < 3; i++) begin
        c2_rc[i] <= CW1'(c1_p[2*i]) - CW1'(c1_p[2*i+1]);
      end
      c2_pay <= c1_pay;
    end
  end

  p2_t                n2_out;
  logic               n2_v, n2_ok;
  logic [2:0][UW-1:0] n2_r;

  lavm_norm #(.IW(CW1), .PW($bits(p2_t)), .FRAC_BITS(F)) u_norm_r (
    .clk(clk), .rst(rst), .en(en), .in_valid(c2_v), .vin(c2_rc), .in_pay(c2_pay),
    .out_valid(n2_v), .unit(n2_r), .ok(n2_ok), .out_pay(n2_out)
  );

  // up = f x r
  logic                     c3_v, c4_v;
  logic signed [2*UW-1:0]   c3_p [6];
  p3_t                      c3_pay, c4_pay;
  logic [2:0][CW2-1:0]      c4_uc;

  always_ff @(posedge clk) begin
    if (rst) begin
      c3_v <= 1'b0;
      c4_v <= 1'b0;
    end else if (en) begin
      c3_v <= n2_v;
      c4_v <= c3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_p[0] <= $signed(n2_out.f[1]) * $signed(n2_r[2]);
      c3_p[1] <= $signed(n2_out.f[2]) * $signed(n2_r[1]);
      c3_p[2] <= $signed(n2_out.f[2]) * $signed(n2_r[0]);
      c3_p[3] <= $signed(n2_out.f[0]) * $signed(n2_r[2]);
      c3_p[4] <= $signed(n2_out.f[0]) * $signed(n2_r[1]);
      c3_p[5] <= $signed(n2_out.f[1]) * $signed(n2_r[0]);
      c3_pay  <= '{eye: n2_out.eye, f: n2_out.f, r: n2_r, deg: n2_out.deg || !n2_ok};

      for (int i = 0; i < 3; i++) begin
        c4_uc[i] <= CW2'(c3_p[2*i]) - CW2'(c3_p[2*i+1]);
      end
      c4_pay <= c3_pay;
    end
  end

  p3_t                n3_out;
  logic               n3_v, n3_ok;
  logic [2:0][UW-1:0] n3_u;

  lavm_norm #(.IW(CW2), .PW($bits(p3_t)), .FRAC_BITS(F)) u_norm_u (
    .clk(clk), .rst(rst), .en(en), .in_valid(c4_v), .vin(c4_uc), .in_pay(c4_pay),
    .out_valid(n3_v), .unit(n3_u), .ok(n3_ok), .out_pay(n3_out)
  );

  // translation: eye split into integer and fraction parts, exact dot product
  logic [2:0][2:0][UW-1:0] ax_c;
  always_comb begin
    ax_c[0] = n3_out.r;
    ax_c[1] = n3_u;
    ax_c[2] = n3_out.f;
  end

  logic                        x1_v, x2_v, x3_v;
  logic signed [UW+W-F-1:0]    x1_ph [3][3];
  logic signed [UW+F:0]        x1_pl [3][3];
  logic [2:0][2:0][UW-1:0]     x1_ax, x2_ax;
  logic                        x1_deg, x2_deg, x3_deg;
  logic signed [SW-1:0]        x2_ip [3];
  logic signed [SW-1:0]        x2_fp [3];
  logic [3:0][FIELD_W-1:0]     x3_el [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_v <= 1'b0;
      x2_v <= 1'b0;
      x3_v <= 1'b0;
    end else if (en) begin
      x1_v <= n3_v;
      x2_v <= x1_v;
      x3_v <= x2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          x1_ph[a][i] <= $signed(ax_c[a][i]) * $signed(n3_out.eye[i][W-1:F]);
          x1_pl[a][i] <= $signed(ax_c[a][i]) * $signed({1'b0, n3_out.eye[i][F-1:0]});
        end
      end
      x1_ax  <= ax_c;
      x1_deg <= n3_out.deg || !n3_ok;

      for (int a = 0; a < 3; a++) begin
        x2_ip[a] <= SW'(x1_ph[a][0]) + SW'(x1_ph[a][1]) + SW'(x1_ph[a][2]);
        x2_fp[a] <= SW'(x1_pl[a][0]) + SW'(x1_pl[a][1]) + SW'(x1_pl[a][2]);
      end
      x2_ax  <= x1_ax;
      x2_deg <= x1_deg;

      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          x3_el[a][i] <= fld(SW'($signed(x2_ax[a][i])));
        end
        x3_el[a][3] <= fld(-(x2_ip[a] + ((x2_fp[a] + HALF) >>> F)));
      end
      x3_deg <= x2_deg;
    end
  end

  // row emitter: holds one matrix, shifts a row out per beat
  logic                    m_v;
  logic [1:0]              row;
  logic                    m_deg;
  logic [3:0][FIELD_W-1:0] m_el [4];
  logic [3:0][FIELD_W-1:0] ld_el [4];
  logic [FIELD_W-1:0]      one_fld;

  assign one_fld = fld(ONE);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 4; j++) begin
        ld_el[k][j] = x3_deg ? ((j == k) ? one_fld : '0) : x3_el[k][j];
      end
    end
    ld_el[3] = {one_fld, {FIELD_W{1'b0}}, {FIELD_W{1'b0}}, {FIELD_W{1'b0}}};
  end

  assign acc_out = m_v && rows.ready;
  assign en      = !m_v || (acc_out && (row == ROW_CONST));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
      row <= ROW_RIGHT;
    end else if (en) begin
      m_v <= x3_v;
      row <= ROW_RIGHT;
    end else if (acc_out) begin
      row <= row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_el  <= ld_el;
      m_deg <= x3_deg;
    end else if (acc_out) begin
      for (int k = 0; k < 3; k++) begin
        m_el[k] <= m_el[k+1];
      end
    end
  end

  // no beat is taken while reset is held
  assign pts.ready       = en && !rst;
  assign rows.valid      = m_v;
  assign rows.row_index  = row;
  assign rows.elem0      = m_el[0][0];
  assign rows.elem1      = m_el[0][1];
  assign rows.elem2      = m_el[0][2];
  assign rows.elem3      = m_el[0][3];
  assign rows.degenerate = m_deg;
  assign rows.last_row   = (row == ROW_CONST);

endmodule
